@@ rtl/jlc_pkg.sv @@
package jlc_pkg;

	// Widths of the byte counter and of the nesting counter.
	localparam int OFFSET_BITS = 32;
	localparam int DEPTH_BITS  = 8;

	// Widths fixed by the channel payloads.
	localparam int BYTE_W  = 8;
	localparam int LIMIT_W = 8;
	localparam int KIND_W  = 3;
	localparam int ERR_W   = 32;

	localparam logic [LIMIT_W-1:0] DEPTH_LIMIT_RST = 8'd64;

	// Error categories reported in error_kind.
	localparam logic [KIND_W-1:0] ERR_STR_CTRL  = 3'd0;
	localparam logic [KIND_W-1:0] ERR_ESC_END   = 3'd1;
	localparam logic [KIND_W-1:0] ERR_BAD_UNI   = 3'd2;
	localparam logic [KIND_W-1:0] ERR_NUL_UNI   = 3'd3;
	localparam logic [KIND_W-1:0] ERR_DEPTH     = 3'd4;
	localparam logic [KIND_W-1:0] ERR_UNMATCHED = 3'd5;
	localparam logic [KIND_W-1:0] ERR_WSPACE    = 3'd6;
	localparam logic [KIND_W-1:0] ERR_NUMBER    = 3'd7;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
	} jlc_item_t;

	// Reported offset keeps the low ERR_W bits of the byte counter.
	function automatic logic [ERR_W-1:0] to_err_off(input logic [OFFSET_BITS-1:0] v);
		logic [OFFSET_BITS+ERR_W-1:0] w;
		w = {{ERR_W{1'b0}}, v};
		return w[ERR_W-1:0];
	endfunction

endpackage

@@ rtl/jlc_channels.sv @@
interface jlc_byte_if
	import jlc_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface jlc_result_if
	import jlc_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic              accepted;
	logic [KIND_W-1:0] error_kind;
	logic [ERR_W-1:0]  error_offset;

	modport source (output valid, output accepted, output error_kind, output error_offset,
		input ready);
	modport sink (input valid, input accepted, input error_kind, input error_offset,
		output ready);
endinterface

interface jlc_cfg_if
	import jlc_pkg::*;
	();
	logic               valid;
	logic               ready;
	logic [LIMIT_W-1:0] depth_limit;

	modport source (output valid, output depth_limit, input ready);
	modport sink (input valid, input depth_limit, output ready);
endinterface

@@ rtl/json_lexical_checker.sv @@
// Each byte waits in the input register until the lexer takes it; its result, if any, is then registered.
// Throughput: one byte per cycle while no result waits to be taken; the lexer state updates as each byte is taken.
// While a result waits to be taken, the input register can still hold one more byte.
// Reset: arst_n clears the lexer state and the valid flags of the input and result
// registers, and sets depth_limit to 64. The configuration port is always ready.
module json_lexical_checker
	import jlc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	jlc_byte_if.sink     bytes,
	jlc_result_if.source result,
	jlc_cfg_if.sink      cfg
);

	logic               cfg_write;
	logic [LIMIT_W-1:0] limit_q;
	logic               take;
	logic               item_valid;
	jlc_item_t          item;

	assign cfg.ready = 1'b1;
	assign cfg_write = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= DEPTH_LIMIT_RST;
		end else if (cfg_write && cfg.ready) begin
			limit_q <= cfg.depth_limit;
		end
	end

	jlc_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.bytes      (bytes),
		.take       (take),
		.item_valid (item_valid),
		.item       (item)
	);

	jlc_lexer u_lexer (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item        (item),
		.depth_limit (limit_q),
		.take        (take),
		.result      (result)
	);

endmodule

@@ rtl/jlc_in_reg.sv @@
module jlc_in_reg
	import jlc_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	jlc_byte_if.sink       bytes,
	input  logic           take,
	output logic           item_valid,
	output jlc_item_t      item
);

	logic      valid_s1;
	jlc_item_t item_s1;

	// The register refills in the same cycle that the lexer takes its byte.
	assign bytes.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			item_s1.data_byte <= bytes.data_byte;
			item_s1.last_byte <= bytes.last_byte;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

@@ rtl/jlc_lexer.sv @@
module jlc_lexer
	import jlc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  jlc_item_t          item,
	input  logic [LIMIT_W-1:0] depth_limit,
	output logic               take,
	jlc_result_if.source       result
);

	localparam logic [3:0] M_OUT   = 4'd0;
	localparam logic [3:0] M_STR   = 4'd1;
	localparam logic [3:0] M_ESC   = 4'd2;
	localparam logic [3:0] M_HEX   = 4'd3;
	localparam logic [3:0] M_NEG   = 4'd4;
	localparam logic [3:0] M_ZERO  = 4'd5;
	localparam logic [3:0] M_INT   = 4'd6;
	localparam logic [3:0] M_FRAC0 = 4'd7;
	localparam logic [3:0] M_FRAC  = 4'd8;
	localparam logic [3:0] M_EXP0  = 4'd9;
	localparam logic [3:0] M_EXPS  = 4'd10;
	localparam logic [3:0] M_EXPD  = 4'd11;

	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
	localparam logic [BYTE_W-1:0] CH_UP_A   = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UP_E   = 8'h45;
	localparam logic [BYTE_W-1:0] CH_UP_F   = 8'h46;
	localparam logic [BYTE_W-1:0] CH_LO_A   = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LO_E   = 8'h65;
	localparam logic [BYTE_W-1:0] CH_LO_F   = 8'h66;
	localparam logic [BYTE_W-1:0] CH_LO_U   = 8'h75;
	localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
	localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
	localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;

	localparam int CMP_W = (DEPTH_BITS + 1 > LIMIT_W) ? DEPTH_BITS + 1 : LIMIT_W;
	localparam logic [OFFSET_BITS-1:0] POS_ONE   = {{(OFFSET_BITS-1){1'b0}}, 1'b1};
	localparam logic [OFFSET_BITS-1:0] POS_MAX   = {OFFSET_BITS{1'b1}};
	localparam logic [DEPTH_BITS-1:0]  DEPTH_ONE = {{(DEPTH_BITS-1){1'b0}}, 1'b1};

	logic [3:0]             mode_q;
	logic [DEPTH_BITS-1:0]  depth_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS-1:0] mark_q;
	logic [2:0]             hex_cnt_q;
	logic                   hex_zero_q;
	logic                   err_seen_q;

	logic                   out_valid_q;
	logic                   out_accepted_q;
	logic [KIND_W-1:0]      out_kind_q;
	logic [ERR_W-1:0]       out_off_q;

	logic [3:0]             mode_n;
	logic [DEPTH_BITS-1:0]  depth_n;
	logic [OFFSET_BITS-1:0] mark_n;
	logic [2:0]             hex_cnt_n;
	logic                   hex_zero_n;
	logic [OFFSET_BITS-1:0] pos_inc;
	logic                   err;
	logic [KIND_W-1:0]      kind;
	logic [OFFSET_BITS-1:0] err_off;
	logic                   has_result;

	logic [BYTE_W-1:0] c;
	logic              is_dig;
	logic              is_hex;
	logic              is_term;
	logic [DEPTH_BITS:0] depth_inc;
	logic              too_deep;

	assign c      = item.data_byte;
	assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
	assign is_hex = is_dig || ((c >= CH_LO_A) && (c <= CH_LO_F))
		|| ((c >= CH_UP_A) && (c <= CH_UP_F));
	assign is_term = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF)
		|| (c == CH_COMMA) || (c == CH_RBRACK) || (c == CH_RBRACE);

	// The extra top bit catches a wrap of the nesting counter itself.
	assign depth_inc = {1'b0, depth_q} + {{DEPTH_BITS{1'b0}}, 1'b1};
	assign too_deep  = depth_inc[DEPTH_BITS] || (CMP_W'(depth_inc) > CMP_W'(depth_limit));
	assign pos_inc   = (pos_q == POS_MAX) ? pos_q : pos_q + POS_ONE;

	always_comb begin
		logic do_tail;
		logic dot_ok;
		logic exp_ok;
		logic go_out;

		mode_n     = mode_q;
		depth_n    = depth_q;
		mark_n     = mark_q;
		hex_cnt_n  = hex_cnt_q;
		hex_zero_n = hex_zero_q;
		err        = 1'b0;
		kind       = ERR_STR_CTRL;
		err_off    = pos_q;
		do_tail    = 1'b0;
		dot_ok     = 1'b0;
		exp_ok     = 1'b0;
		go_out     = 1'b0;

		case (mode_q)
			M_STR: begin
				if (c < CH_SPACE) begin
					err  = 1'b1;
					kind = ERR_STR_CTRL;
				end else if (c == CH_BSLASH) begin
					mark_n = pos_q;
					mode_n = M_ESC;
				end else if (c == CH_QUOTE) begin
					mode_n = M_OUT;
				end
			end
			M_ESC: begin
				if (c == CH_LO_U) begin
					mode_n     = M_HEX;
					hex_cnt_n  = 3'd0;
					hex_zero_n = 1'b1;
				end else begin
					mode_n = M_STR;
				end
			end
			M_HEX: begin
				err_off = mark_q;
				if (!is_hex) begin
					err  = 1'b1;
					kind = ERR_BAD_UNI;
				end else begin
					hex_zero_n = hex_zero_q && (c == CH_ZERO);
					hex_cnt_n  = hex_cnt_q + 3'd1;
					if (hex_cnt_q == 3'd3) begin
						if (hex_zero_n) begin
							err  = 1'b1;
							kind = ERR_NUL_UNI;
						end else begin
							mode_n = M_STR;
						end
					end
				end
			end
			M_NEG: begin
				if (!is_dig) begin
					err     = 1'b1;
					kind    = ERR_NUMBER;
					err_off = mark_q;
				end else begin
					mode_n = (c == CH_ZERO) ? M_ZERO : M_INT;
				end
			end
			M_ZERO: begin
				do_tail = 1'b1;
				dot_ok  = 1'b1;
				exp_ok  = 1'b1;
			end
			M_INT: begin
				do_tail = !is_dig;
				dot_ok  = 1'b1;
				exp_ok  = 1'b1;
			end
			M_FRAC0, M_EXPS: begin
				if (!is_dig) begin
					err     = 1'b1;
					kind    = ERR_NUMBER;
					err_off = mark_q;
				end else begin
					mode_n = (mode_q == M_FRAC0) ? M_FRAC : M_EXPD;
				end
			end
			M_FRAC: begin
				do_tail = !is_dig;
				exp_ok  = 1'b1;
			end
			M_EXP0: begin
				if ((c == CH_PLUS) || (c == CH_MINUS)) begin
					mode_n = M_EXPS;
				end else if (is_dig) begin
					mode_n = M_EXPD;
				end else begin
					err     = 1'b1;
					kind    = ERR_NUMBER;
					err_off = mark_q;
				end
			end
			M_EXPD: begin
				do_tail = !is_dig;
			end
			default: begin
				go_out = 1'b1;
			end
		endcase

		// A terminator ends the number and is then treated as an outside byte.
		if (do_tail) begin
			if (dot_ok && (c == CH_DOT)) begin
				mode_n = M_FRAC0;
			end else if (exp_ok && ((c == CH_LO_E) || (c == CH_UP_E))) begin
				mode_n = M_EXP0;
			end else if (is_term) begin
				go_out = 1'b1;
			end else begin
				err     = 1'b1;
				kind    = ERR_NUMBER;
				err_off = mark_q;
			end
		end

		if (go_out) begin
			mode_n  = M_OUT;
			err_off = pos_q;
			if (c == CH_QUOTE) begin
				mode_n = M_STR;
			end else if ((c == CH_LBRACE) || (c == CH_LBRACK)) begin
				if (too_deep) begin
					err  = 1'b1;
					kind = ERR_DEPTH;
				end else begin
					depth_n = depth_inc[DEPTH_BITS-1:0];
				end
			end else if ((c == CH_RBRACE) || (c == CH_RBRACK)) begin
				if (depth_q == '0) begin
					err  = 1'b1;
					kind = ERR_UNMATCHED;
				end else begin
					depth_n = depth_q - DEPTH_ONE;
				end
			end else if ((c < CH_SPACE) && (c != CH_TAB) && (c != CH_CR) && (c != CH_LF)) begin
				err  = 1'b1;
				kind = ERR_WSPACE;
			end else if ((c == CH_MINUS) || is_dig) begin
				mark_n = pos_q;
				mode_n = (c == CH_MINUS) ? M_NEG : ((c == CH_ZERO) ? M_ZERO : M_INT);
			end
		end

		// Numbers and escapes left unfinished by the last byte.
		if (!err && item.last_byte) begin
			if ((mode_n == M_NEG) || (mode_n == M_FRAC0) || (mode_n == M_EXP0)
				|| (mode_n == M_EXPS)) begin
				err     = 1'b1;
				kind    = ERR_NUMBER;
				err_off = mark_n;
			end else if (mode_n == M_ESC) begin
				err     = 1'b1;
				kind    = ERR_ESC_END;
				err_off = pos_inc;
			end else if (mode_n == M_HEX) begin
				err     = 1'b1;
				kind    = ERR_BAD_UNI;
				err_off = mark_n;
			end
		end
	end

	// One result per document: at its first error, or at its last byte.
	assign has_result = !err_seen_q && (err || item.last_byte);
	assign take       = item_valid && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_OUT;
			depth_q    <= '0;
			pos_q      <= '0;
			mark_q     <= '0;
			hex_cnt_q  <= 3'd0;
			hex_zero_q <= 1'b1;
			err_seen_q <= 1'b0;
		end else if (take) begin
			if (item.last_byte) begin
				mode_q     <= M_OUT;
				depth_q    <= '0;
				pos_q      <= '0;
				mark_q     <= '0;
				hex_cnt_q  <= 3'd0;
				hex_zero_q <= 1'b1;
				err_seen_q <= 1'b0;
			end else if (err_seen_q || err) begin
				// Apart from the byte position, lexer state is frozen until the document ends.
				pos_q      <= pos_inc;
				err_seen_q <= 1'b1;
			end else begin
				mode_q     <= mode_n;
				depth_q    <= depth_n;
				pos_q      <= pos_inc;
				mark_q     <= mark_n;
				hex_cnt_q  <= hex_cnt_n;
				hex_zero_q <= hex_zero_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= has_result;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && has_result) begin
			out_accepted_q <= !err;
			out_kind_q     <= err ? kind : ERR_STR_CTRL;
			out_off_q      <= err ? to_err_off(err_off) : '0;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.accepted     = out_accepted_q;
	assign result.error_kind   = out_kind_q;
	assign result.error_offset = out_off_q;

	// The count rests at four after a complete escape and is cleared on the next one.
	a_hex_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		hex_cnt_q <= 3'd4)
		else $error("hex digit count passed four");

	a_accept_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_accepted_q) |-> (out_kind_q == ERR_STR_CTRL && out_off_q == '0))
		else $error("accepted result carries error information");

	a_result_from_take: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(take))
		else $error("result appeared without a byte being processed");

	a_pos_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !item.last_byte && pos_q != POS_MAX) |=> (pos_q == $past(pos_q) + POS_ONE))
		else $error("byte position did not advance");

	a_doc_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(take && item.last_byte) |=> (pos_q == '0 && !err_seen_q && depth_q == '0))
		else $error("state not cleared after last byte");

endmodule
